[hdl/pru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg: shared types and constants for the PNG row unfilter
// Operation word passed from the front end to the back end, filter codes,
// configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int DATA_W     = 8;
  localparam int CFG_RB_W   = 13;
  localparam int CFG_BPP_W  = 4;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int COL_W      = 16;
  localparam int SLOT_W     = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'b1;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  localparam logic [DATA_W-1:0] FLT_MAX_CODE = 8'd4;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_ERROR  = 2'd1,
    OP_DATA   = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    filter_t               filter;
    logic [DATA_W-1:0]     data;
    logic [COL_W-1:0]      column;
    logic [SLOT_W-1:0]     slot;
    logic                  left_ok;
    logic                  first_row;
    logic                  row_last;
  } op_t;

endpackage

[hdl/pru_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_front: row tracking and byte classification
// Holds configuration, tracks column, filter type and error state, and
// turns each accepted byte into a filter, error or data operation.
// ----------------------------------------------------------------------------
module pru_front
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_fire,
  input  logic [DATA_W-1:0]    in_byte,
  input  logic                 in_start,
  output logic                 push,
  output op_t                  push_op
);

  localparam int AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CMPW = ((AW > CFG_RB_W) ? AW : CFG_RB_W) + 1;
  localparam int PI_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [CFG_RB_W-1:0]  row_bytes;
  logic [CFG_BPP_W-1:0] bytes_per_pixel;
  logic [AW-1:0]        column;
  filter_t              filter_kind;
  logic                 on_first_row;
  logic                 awaiting_filter;
  logic                 error_hold;
  logic [SLOT_W-1:0]    mod_cnt [MAX_PIXEL_BYTES];

  logic [CMPW-1:0]      rb_eff;
  logic [CFG_BPP_W-1:0] bpp_eff;
  logic [SLOT_W-1:0]    slot;
  logic                 left_ok;
  logic                 is_last;
  logic                 hold_eff;
  logic                 await_eff;
  logic                 first_eff;
  logic                 bad_filter;

  always_comb begin
    rb_eff = CMPW'(row_bytes);
    if (rb_eff == '0) begin
      rb_eff = CMPW'(1);
    end else if (rb_eff > CMPW'(MAX_ROW_BYTES)) begin
      rb_eff = CMPW'(MAX_ROW_BYTES);
    end
    bpp_eff = bytes_per_pixel;
    if (bpp_eff == '0) begin
      bpp_eff = CFG_BPP_W'(1);
    end else if (bpp_eff > CFG_BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = CFG_BPP_W'(MAX_PIXEL_BYTES);
    end
  end

  assign slot       = mod_cnt[PI_W'(bpp_eff - CFG_BPP_W'(1))];
  assign left_ok    = CMPW'(column) >= CMPW'(bpp_eff);
  assign is_last    = (CMPW'(column) + CMPW'(1)) >= rb_eff;
  assign hold_eff   = in_start ? 1'b0 : error_hold;
  assign await_eff  = in_start ? 1'b1 : awaiting_filter;
  assign first_eff  = in_start ? 1'b1 : on_first_row;
  assign bad_filter = in_byte > FLT_MAX_CODE;

  always_comb begin
    push            = in_fire && !hold_eff;
    push_op.filter  = filter_kind;
    push_op.data    = in_byte;
    push_op.column  = COL_W'(column);
    push_op.slot    = slot;
    push_op.left_ok = left_ok;
    push_op.first_row = first_eff;
    push_op.row_last  = is_last;
    if (await_eff) begin
      push_op.kind = bad_filter ? OP_ERROR : OP_FILTER;
    end else begin
      push_op.kind = OP_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= CFG_RB_W'(1);
      bytes_per_pixel <= CFG_BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_BYTES: row_bytes       <= cfg_data[CFG_RB_W-1:0];
        REG_BPP:       bytes_per_pixel <= cfg_data[CFG_BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      filter_kind     <= FLT_NONE;
      on_first_row    <= 1'b1;
      awaiting_filter <= 1'b1;
      error_hold      <= 1'b0;
      for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
        mod_cnt[m] <= '0;
      end
    end else if (in_fire) begin
      if (in_start) begin
        error_hold      <= 1'b0;
        on_first_row    <= 1'b1;
        awaiting_filter <= 1'b1;
        column          <= '0;
      end
      if (!hold_eff) begin
        if (await_eff) begin
          if (bad_filter) begin
            error_hold <= 1'b1;
          end else begin
            filter_kind     <= filter_t'(in_byte[2:0]);
            awaiting_filter <= 1'b0;
            column          <= '0;
            for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
              mod_cnt[m] <= '0;
            end
          end
        end else if (is_last) begin
          column          <= '0;
          awaiting_filter <= 1'b1;
          on_first_row    <= 1'b0;
        end else begin
          column <= column + AW'(1);
          for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
            mod_cnt[m] <= (mod_cnt[m] == SLOT_W'(m)) ? '0 : mod_cnt[m] + SLOT_W'(1);
          end
        end
      end
    end
  end

endmodule

[hdl/pru_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_queue: operation queue between front and back end
// Small register FIFO; push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
module pru_queue
  import pru_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  head_op,
  output logic empty
);

  op_t                entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = count == Q_CNT_W'(Q_DEPTH);
  assign empty   = count == '0;
  assign head_op = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/pru_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_back: reconstruction datapath
// Reads the line store, applies the row filter with left, above and
// upper-left neighbors, updates history and drives the output register.
// ----------------------------------------------------------------------------
module pru_back
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  op_t               head_op,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_status
);

  localparam int AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PI_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [DATA_W-1:0] line_mem [MAX_ROW_BYTES];
  logic [DATA_W-1:0] left_hist [MAX_PIXEL_BYTES];
  logic [DATA_W-1:0] upleft_hist [MAX_PIXEL_BYTES];

  logic              s1_valid;
  op_t               s1_op;
  logic [DATA_W-1:0] mem_q;
  logic              fwd;
  logic [DATA_W-1:0] fwd_data;

  logic              produces;
  logic              s1_adv;
  logic              s1_write;
  logic [PI_W-1:0]   s1_slot;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] ul;
  logic [DATA_W:0]   sum_ab;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [9:0]        dd;
  logic [DATA_W-1:0] pred;
  logic [DATA_W-1:0] res;

  assign produces = s1_op.kind != OP_FILTER;
  assign s1_adv   = s1_valid && (!produces || !out_valid || out_ready);
  assign pop      = !q_empty && (!s1_valid || s1_adv);
  assign s1_write = s1_adv && (s1_op.kind == OP_DATA);
  assign s1_slot  = s1_op.slot[PI_W-1:0];

  always_comb begin
    a  = s1_op.left_ok ? left_hist[s1_slot] : '0;
    b  = s1_op.first_row ? '0 : (fwd ? fwd_data : mem_q);
    ul = (s1_op.left_ok && !s1_op.first_row) ? upleft_hist[s1_slot] : '0;
    sum_ab = {1'b0, a} + {1'b0, b};
    pa = (b >= ul) ? 10'(b - ul) : 10'(ul - b);
    pb = (a >= ul) ? 10'(a - ul) : 10'(ul - a);
    dd = {1'b0, sum_ab} - {1'b0, ul, 1'b0};
    pc = dd[9] ? 10'(-dd) : dd;
    case (s1_op.filter)
      FLT_SUB: pred = a;
      FLT_UP:  pred = b;
      FLT_AVG: pred = sum_ab[DATA_W:1];
      FLT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = ul;
        end
      end
      default: pred = '0;
    endcase
    res = s1_op.data + pred;
  end

  // line store: registered read on pop, write when a data word retires
  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q <= line_mem[head_op.column[AW-1:0]];
    end
    if (s1_write) begin
      line_mem[s1_op.column[AW-1:0]] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op    <= head_op;
      fwd      <= s1_write && (s1_op.column[AW-1:0] == head_op.column[AW-1:0]);
      fwd_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= '0;
        upleft_hist[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_op.kind == OP_FILTER) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_hist[i]   <= '0;
          upleft_hist[i] <= '0;
        end
      end else if (s1_op.kind == OP_DATA) begin
        left_hist[s1_slot]   <= res;
        upleft_hist[s1_slot] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && produces) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && produces) begin
      if (s1_op.kind == OP_DATA) begin
        out_byte   <= res;
        out_last   <= s1_op.row_last;
        out_status <= 1'b0;
      end else begin
        out_byte   <= '0;
        out_last   <= 1'b0;
        out_status <= 1'b1;
      end
    end
  end

endmodule

[hdl/png_row_unfilter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_top: PNG scanline filter reconstruction
// Filter type byte per row, then row_bytes filtered bytes; one rebuilt
// byte out per data byte, using None, Sub, Up, Average or Paeth.
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// s_*       in   8+1    tdata: data_byte; tuser: image_start
// m_*       out  8+1+1  tdata: out_byte; tlast: row_last; tuser: status
// cfg_*     in   1+13   index 0 row_bytes, index 1 bytes_per_pixel
//
// One word per cycle while the output does not stall; each word passes the
// queue, the line store read and the output register. Valid filter bytes
// and dropped bytes give no output; a bad filter byte gives a status word.
// Reset is synchronous and clears control state, not the line store. A
// four-word queue keeps input flowing while the output stalls, until full.
// ----------------------------------------------------------------------------
module png_row_unfilter_top
  import pru_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tuser,   // [0] image_start
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] out_byte
  output logic                 m_tlast,
  output logic                 m_tuser,   // [0] status
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic in_fire;
  logic push;
  op_t  push_op;
  logic q_full;
  logic q_empty;
  logic pop;
  op_t  head_op;

  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  pru_front #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .in_byte  (s_tdata),
    .in_start (s_tuser),
    .push     (push),
    .push_op  (push_op)
  );

  pru_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .pop    (pop),
    .head_op(head_op),
    .empty  (q_empty)
  );

  pru_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_status(m_tuser)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (!m_tlast && m_tdata == 8'd0))
    else $error("error word carries data");

  a_drop_after_error: assert property (@(posedge clk) disable iff (rst)
    (push && push_op.kind == OP_ERROR) |=> !(in_fire && !s_tuser && push))
    else $error("word queued after bad filter type");
`endif

endmodule
